/* design/lock_manager_fifo_waiters_top_assert.svh */
// Assertion macros for the lock manager.
`ifndef LOCK_MANAGER_FIFO_WAITERS_TOP_ASSERT_SVH
`define LOCK_MANAGER_FIFO_WAITERS_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LMFW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lock manager check failed");
`define LMFW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lock manager check failed");
`else
`define LMFW_ASSERT_SAME(label, clk, rst, ante, cons)
`define LMFW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/lmfw_pkg.sv */
// Types and codes shared by the lock manager files.
package lmfw_pkg;

   typedef enum logic [2:0] {
      MODE_INIT    = 3'd0,
      MODE_LOCK    = 3'd1,
      MODE_TRYLOCK = 3'd2,
      MODE_UNLOCK  = 3'd3,
      MODE_RESUME  = 3'd4,
      MODE_CLEAR   = 3'd5
   } mode_type;

   typedef enum logic [3:0] {
      ST_GRANTED   = 4'd0,
      ST_SUSPENDED = 4'd1,
      ST_BUSY      = 4'd2,
      ST_RELEASED  = 4'd3,
      ST_WAKE      = 4'd4,
      ST_NONE      = 4'd5,
      ST_DONE      = 4'd6,
      ST_ERROR     = 4'd7,
      ST_FULL      = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      EK_NONE       = 3'd0,
      EK_REENTRANT  = 3'd1,
      EK_NOT_LOCKED = 3'd2,
      EK_NOT_HOLDER = 3'd3,
      EK_BAD_REG    = 3'd4
   } err_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_SR_ISSUE,
      S_SR_CMP,
      S_SH_CHECK,
      S_SH_WR,
      S_SC_CHECK,
      S_SC_DATA,
      S_OUT
   } state_type;

   typedef struct packed {
      logic       set_reg;
      logic       clr_reg;
      logic       grant;
      logic       release_lock;
      logic       inc_cnt;
      logic       dec_cnt;
      logic [7:0] task_id;
   } tbl_cmd_type;

endpackage

/* design/lmfw_if.sv */
// Request and response channel interfaces.
interface lmfw_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [2:0] lock_index;
   logic [7:0] task_id;
   modport source (output valid, mode, lock_index, task_id, input ready);
   modport sink (input valid, mode, lock_index, task_id, output ready);
endinterface

interface lmfw_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] status;
   logic [2:0] error_kind;
   logic [2:0] out_lock;
   logic [7:0] out_task;
   logic       last;
   modport source (output valid, status, error_kind, out_lock, out_task, last, input ready);
   modport sink (input valid, status, error_kind, out_lock, out_task, last, output ready);
endinterface

/* design/lmfw_ram.sv */
// Generic single write, single read RAM with registered read data.
module lmfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* design/lmfw_table.sv */
// Per-mutex registration, holder and waiter count registers.
module lmfw_table #(
   parameter int SLOTS = 8,
   parameter int LW    = 3,
   parameter int CW    = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [LW-1:0]        idx,
   input  lmfw_pkg::tbl_cmd_type cmd,
   output logic                 registered,
   output logic                 held,
   output logic [7:0]           holder,
   output logic [CW-1:0]        count
);
   logic          reg_ff    [SLOTS];
   logic          held_ff   [SLOTS];
   logic [7:0]    holder_ff [SLOTS];
   logic [CW-1:0] count_ff  [SLOTS];
   logic          hit;

   assign hit = (int'(idx) < SLOTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            reg_ff[i]    <= 1'b0;
            held_ff[i]   <= 1'b0;
            holder_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
      end else if (hit) begin
         if (cmd.set_reg) begin
            reg_ff[idx] <= 1'b1;
         end
         if (cmd.clr_reg) begin
            reg_ff[idx] <= 1'b0;
         end
         if (cmd.grant) begin
            held_ff[idx]   <= 1'b1;
            holder_ff[idx] <= cmd.task_id;
         end
         if (cmd.release_lock) begin
            held_ff[idx]   <= 1'b0;
            holder_ff[idx] <= '0;
         end
         if (cmd.inc_cnt) begin
            count_ff[idx] <= count_ff[idx] + CW'(1);
         end
         if (cmd.dec_cnt) begin
            count_ff[idx] <= count_ff[idx] - CW'(1);
         end
      end
   end

   assign registered = hit ? reg_ff[idx] : 1'b0;
   assign held       = hit ? held_ff[idx] : 1'b0;
   assign holder     = hit ? holder_ff[idx] : '0;
   assign count      = hit ? count_ff[idx] : '0;
endmodule

/* design/lock_manager_fifo_waiters_top.sv */
// Lock manager top level: request sequencer over the lock table and waiter RAM.
//
// One request beat enters on req_chan (mode, lock_index, task_id) when ready
// is high; ready is high only while the sequencer is idle. Each request gives
// one response beat on rsp_chan, or for resume one beat per woken task (a single
// none beat if no task wakes), the final beat carrying last.
// Init, clear, trylock and simple lock or unlock faults pass from idle through
// the exec state to the output state. A lock or unlock that consults the waiter
// list checks one entry per issue and compare step, and an unlock or wake that
// removes an entry moves each later entry up through check and write states; a
// resume scan visits each mutex in turn, plus the pops. All list work goes
// through the single RAM read port.
// Reset clears registration, held bits, holders and waiter counts; waiter RAM
// contents need no clearing.
// A stalled response holds the sequencer: no further work is done and no new
// request is taken until the pending response beat is accepted.
module lock_manager_fifo_waiters_top #(
   parameter int NUM_LOCKS    = 8,
   parameter int QUEUE_DEPTH  = 16,
   parameter int TASK_ID_BITS = 8
) (
   input logic     clock,
   input logic     reset,
   lmfw_req_if.sink   req_chan,
   lmfw_rsp_if.source rsp_chan
);
   localparam int SLOTS = (NUM_LOCKS < 8) ? NUM_LOCKS : 8;
   localparam int LW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int TW    = (TASK_ID_BITS < 8) ? TASK_ID_BITS : 8;
   localparam int AW    = LW + QW;
   localparam logic [7:0] TMASK = (TASK_ID_BITS >= 8) ? 8'hFF :
                                  8'((1 << TASK_ID_BITS) - 1);

   lmfw_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [2:0]    mode_ff, mode_in;
   logic [2:0]    idx_ff, idx_in;
   logic [7:0]    task_ff, task_in;
   logic [LW:0]   cur_ff, cur_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          pend_ff, pend_in;
   logic [LW-1:0] pend_lock_ff, pend_lock_in;
   logic [7:0]    pend_task_ff, pend_task_in;
   logic [3:0]    st_ff, st_in;
   logic [2:0]    ek_ff, ek_in;
   logic [2:0]    olock_ff, olock_in;
   logic [7:0]    otask_ff, otask_in;
   logic          last_ff, last_in;

   lmfw_pkg::tbl_cmd_type cmd;
   logic          t_reg, t_held;
   logic [7:0]    t_holder;
   logic [CW-1:0] t_cnt;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [TW-1:0] wdata, rdata;
   logic [CW:0]   pos_next;

   lmfw_table #(.SLOTS(SLOTS), .LW(LW), .CW(CW)) u_table (
      .clock(clock), .reset(reset), .idx(cur_ff[LW-1:0]), .cmd(cmd),
      .registered(t_reg), .held(t_held), .holder(t_holder), .count(t_cnt)
   );

   lmfw_ram #(.WIDTH(TW), .DEPTH(SLOTS << QW)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   assign pos_next = (CW + 1)'(pos_ff) + (CW + 1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmfw_pkg::S_IDLE;
         ret_ff   <= lmfw_pkg::S_IDLE;
         pend_ff  <= 1'b0;
         cur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pend_ff  <= pend_in;
         cur_ff   <= cur_in;
      end
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      task_ff      <= task_in;
      pos_ff       <= pos_in;
      pend_lock_ff <= pend_lock_in;
      pend_task_ff <= pend_task_in;
      st_ff        <= st_in;
      ek_ff        <= ek_in;
      olock_ff     <= olock_in;
      otask_ff     <= otask_in;
      last_ff      <= last_in;
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      task_in      = task_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      pend_in      = pend_ff;
      pend_lock_in = pend_lock_ff;
      pend_task_in = pend_task_ff;
      st_in        = st_ff;
      ek_in        = ek_ff;
      olock_in     = olock_ff;
      otask_in     = otask_ff;
      last_in      = last_ff;
      cmd          = '0;
      cmd.task_id  = task_ff;
      we           = 1'b0;
      waddr        = {cur_ff[LW-1:0], pos_ff[QW-1:0]};
      wdata        = task_ff[TW-1:0];
      raddr        = {cur_ff[LW-1:0], pos_ff[QW-1:0]};
      unique case (state_ff)
         lmfw_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               mode_in  = req_chan.mode;
               idx_in   = req_chan.lock_index;
               task_in  = req_chan.task_id & TMASK;
               cur_in   = (LW + 1)'(req_chan.lock_index);
               state_in = lmfw_pkg::S_EXEC;
            end
         end
         lmfw_pkg::S_EXEC: begin
            state_in = lmfw_pkg::S_OUT;
            ret_in   = lmfw_pkg::S_IDLE;
            ek_in    = lmfw_pkg::EK_NONE;
            olock_in = idx_ff;
            otask_in = task_ff;
            last_in  = 1'b1;
            pos_in   = '0;
            if (mode_ff == lmfw_pkg::MODE_RESUME) begin
               cur_in   = '0;
               pend_in  = 1'b0;
               state_in = lmfw_pkg::S_SC_CHECK;
            end else if (mode_ff > lmfw_pkg::MODE_CLEAR) begin
               st_in = lmfw_pkg::ST_ERROR;
            end else if (int'(idx_ff) >= NUM_LOCKS) begin
               st_in = lmfw_pkg::ST_ERROR;
               ek_in = lmfw_pkg::EK_BAD_REG;
               if (mode_ff == lmfw_pkg::MODE_INIT || mode_ff == lmfw_pkg::MODE_CLEAR) begin
                  otask_in = '0;
               end
            end else begin
               unique case (mode_ff)
                  lmfw_pkg::MODE_INIT: begin
                     otask_in = '0;
                     if (t_reg) begin
                        st_in = lmfw_pkg::ST_ERROR;
                        ek_in = lmfw_pkg::EK_BAD_REG;
                     end else begin
                        cmd.set_reg      = 1'b1;
                        cmd.release_lock = 1'b1;
                        st_in            = lmfw_pkg::ST_DONE;
                     end
                  end
                  lmfw_pkg::MODE_CLEAR: begin
                     otask_in    = '0;
                     cmd.clr_reg = 1'b1;
                     st_in       = lmfw_pkg::ST_DONE;
                  end
                  lmfw_pkg::MODE_LOCK: begin
                     if (!t_held) begin
                        cmd.grant = 1'b1;
                        st_in     = lmfw_pkg::ST_GRANTED;
                     end else if (t_holder == task_ff) begin
                        st_in = lmfw_pkg::ST_ERROR;
                        ek_in = lmfw_pkg::EK_REENTRANT;
                     end else begin
                        state_in = lmfw_pkg::S_SR_ISSUE;
                     end
                  end
                  lmfw_pkg::MODE_TRYLOCK: begin
                     if (!t_held) begin
                        cmd.grant = 1'b1;
                        st_in     = lmfw_pkg::ST_GRANTED;
                     end else begin
                        st_in = lmfw_pkg::ST_BUSY;
                     end
                  end
                  default: begin
                     if (!t_held) begin
                        st_in = lmfw_pkg::ST_ERROR;
                        ek_in = lmfw_pkg::EK_NOT_LOCKED;
                     end else if (t_holder != task_ff) begin
                        st_in = lmfw_pkg::ST_ERROR;
                        ek_in = lmfw_pkg::EK_NOT_HOLDER;
                     end else begin
                        cmd.release_lock = 1'b1;
                        state_in         = lmfw_pkg::S_SR_ISSUE;
                     end
                  end
               endcase
            end
         end
         lmfw_pkg::S_SR_ISSUE: begin
            if (pos_ff >= t_cnt) begin
               state_in = lmfw_pkg::S_OUT;
               if (mode_ff == lmfw_pkg::MODE_LOCK) begin
                  if (int'(t_cnt) >= QUEUE_DEPTH) begin
                     st_in = lmfw_pkg::ST_FULL;
                  end else begin
                     we          = 1'b1;
                     waddr       = {cur_ff[LW-1:0], t_cnt[QW-1:0]};
                     cmd.inc_cnt = 1'b1;
                     st_in       = lmfw_pkg::ST_SUSPENDED;
                  end
               end else begin
                  st_in = lmfw_pkg::ST_RELEASED;
               end
            end else begin
               state_in = lmfw_pkg::S_SR_CMP;
            end
         end
         lmfw_pkg::S_SR_CMP: begin
            if (rdata == task_ff[TW-1:0]) begin
               if (mode_ff == lmfw_pkg::MODE_LOCK) begin
                  st_in    = lmfw_pkg::ST_SUSPENDED;
                  state_in = lmfw_pkg::S_OUT;
               end else begin
                  state_in = lmfw_pkg::S_SH_CHECK;
               end
            end else begin
               pos_in   = pos_next[CW-1:0];
               state_in = lmfw_pkg::S_SR_ISSUE;
            end
         end
         lmfw_pkg::S_SH_CHECK: begin
            raddr = {cur_ff[LW-1:0], pos_next[QW-1:0]};
            if (pos_next < (CW + 1)'(t_cnt)) begin
               state_in = lmfw_pkg::S_SH_WR;
            end else begin
               cmd.dec_cnt = 1'b1;
               if (mode_ff == lmfw_pkg::MODE_RESUME) begin
                  cur_in   = cur_ff + (LW + 1)'(1);
                  state_in = lmfw_pkg::S_SC_CHECK;
               end else begin
                  st_in    = lmfw_pkg::ST_RELEASED;
                  state_in = lmfw_pkg::S_OUT;
               end
            end
         end
         lmfw_pkg::S_SH_WR: begin
            we       = 1'b1;
            wdata    = rdata;
            pos_in   = pos_next[CW-1:0];
            state_in = lmfw_pkg::S_SH_CHECK;
         end
         lmfw_pkg::S_SC_CHECK: begin
            pos_in   = '0;
            ek_in    = lmfw_pkg::EK_NONE;
            olock_in = 3'(pend_lock_ff);
            otask_in = pend_task_ff;
            st_in    = lmfw_pkg::ST_WAKE;
            if (int'(cur_ff) >= SLOTS) begin
               ret_in   = lmfw_pkg::S_IDLE;
               last_in  = 1'b1;
               state_in = lmfw_pkg::S_OUT;
               if (!pend_ff) begin
                  st_in    = lmfw_pkg::ST_NONE;
                  olock_in = '0;
                  otask_in = '0;
               end
            end else if (t_reg && !t_held && t_cnt != '0) begin
               if (pend_ff) begin
                  pend_in  = 1'b0;
                  ret_in   = lmfw_pkg::S_SC_CHECK;
                  last_in  = 1'b0;
                  state_in = lmfw_pkg::S_OUT;
               end else begin
                  state_in = lmfw_pkg::S_SC_DATA;
               end
            end else begin
               cur_in = cur_ff + (LW + 1)'(1);
            end
         end
         lmfw_pkg::S_SC_DATA: begin
            pend_in      = 1'b1;
            pend_lock_in = cur_ff[LW-1:0];
            pend_task_in = 8'(rdata);
            state_in     = lmfw_pkg::S_SH_CHECK;
         end
         lmfw_pkg::S_OUT: begin
            if (rsp_chan.ready) begin
               state_in = ret_ff;
            end
         end
         default: state_in = lmfw_pkg::S_IDLE;
      endcase
   end

   assign req_chan.ready      = (state_ff == lmfw_pkg::S_IDLE);
   assign rsp_chan.valid      = (state_ff == lmfw_pkg::S_OUT);
   assign rsp_chan.status     = st_ff;
   assign rsp_chan.error_kind = ek_ff;
   assign rsp_chan.out_lock   = olock_ff;
   assign rsp_chan.out_task   = otask_ff;
   assign rsp_chan.last       = last_ff;

`include "lock_manager_fifo_waiters_top_assert.svh"

   `LMFW_ASSERT_SAME(a_one_side, clock, reset, req_chan.ready, !rsp_chan.valid)
   `LMFW_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `LMFW_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, int'(t_cnt) <= QUEUE_DEPTH)
   `LMFW_ASSERT_SAME(a_wake_pending, clock, reset, rsp_chan.valid && rsp_chan.status == lmfw_pkg::ST_WAKE && !rsp_chan.last, ret_ff == lmfw_pkg::S_SC_CHECK)

endmodule
